/* hdl/bqf_pkg.sv */
// ----------------------------------------------------------------------------
// bqf_pkg
// Shared types, widths and register codes for the stereo biquad filter.
// ----------------------------------------------------------------------------
package bqf_pkg;

  // Channel count and history addressing
  localparam int CHANNELS = 2;
  localparam int CH_IDX_W = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;

  // Datapath widths
  localparam int SAMPLE_W   = 24;
  localparam int COEF_W     = 32;
  localparam int PROD_W     = COEF_W + SAMPLE_W;  // one coefficient times one sample
  localparam int SUM_W      = PROD_W + 2;         // three products summed
  localparam int ACC_W      = PROD_W + 3;         // five products summed
  localparam int FRAC_SHIFT = 28;                 // Q.51 down to Q.23
  localparam int Q_W        = ACC_W - FRAC_SHIFT;

  localparam logic signed [ACC_W-1:0] ROUND_BIAS = ACC_W'(64'sd134217728);
  localparam logic [SAMPLE_W-1:0] SAT_MAX = 24'h7FFFFF;
  localparam logic [SAMPLE_W-1:0] SAT_MIN = 24'h800000;

  // Configuration port
  localparam int CFG_ADDR_W = 3;
  localparam logic [CFG_ADDR_W-1:0] REG_B0 = 3'd0;
  localparam logic [CFG_ADDR_W-1:0] REG_B1 = 3'd1;
  localparam logic [CFG_ADDR_W-1:0] REG_B2 = 3'd2;
  localparam logic [CFG_ADDR_W-1:0] REG_A1 = 3'd3;
  localparam logic [CFG_ADDR_W-1:0] REG_A2 = 3'd4;

  localparam logic [COEF_W-1:0] B0_RESET = 32'h1000_0000;  // 1.0 in Q4.28

  typedef struct packed {
    logic signed [COEF_W-1:0] b0;
    logic signed [COEF_W-1:0] b1;
    logic signed [COEF_W-1:0] b2;
    logic signed [COEF_W-1:0] a1;
    logic signed [COEF_W-1:0] a2;
  } coef_t;

  // One channel's history entry
  typedef struct packed {
    logic signed [SAMPLE_W-1:0] x1;
    logic signed [SAMPLE_W-1:0] x2;
    logic signed [SAMPLE_W-1:0] y1;
    logic signed [SAMPLE_W-1:0] y2;
  } hist_t;

  // Fold the channel field onto the history entries
  function automatic logic [CH_IDX_W-1:0] chan_index(input logic ch);
    logic [CH_IDX_W-1:0] idx;
    idx = '0;
    if (CHANNELS > 1) begin
      idx = CH_IDX_W'(ch);
    end
    return idx;
  endfunction

endpackage

/* hdl/bqf_coef_regs.sv */
// ----------------------------------------------------------------------------
// bqf_coef_regs
// Coefficient register file: decodes configuration writes into b0..a2.
// ----------------------------------------------------------------------------
module bqf_coef_regs (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            cfg_valid,
  output logic                            cfg_ready,
  input  logic [bqf_pkg::CFG_ADDR_W-1:0]  cfg_addr,
  input  logic [bqf_pkg::COEF_W-1:0]      cfg_data,
  output bqf_pkg::coef_t                  coef
);

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      coef.b0 <= bqf_pkg::B0_RESET;
      coef.b1 <= '0;
      coef.b2 <= '0;
      coef.a1 <= '0;
      coef.a2 <= '0;
    end else if (cfg_valid) begin
      case (cfg_addr)
        bqf_pkg::REG_B0: coef.b0 <= cfg_data;
        bqf_pkg::REG_B1: coef.b1 <= cfg_data;
        bqf_pkg::REG_B2: coef.b2 <= cfg_data;
        bqf_pkg::REG_A1: coef.a1 <= cfg_data;
        bqf_pkg::REG_A2: coef.a2 <= cfg_data;
        default: ;  // drop writes to unmapped indexes
      endcase
    end
  end

endmodule

/* hdl/stereo_biquad_filter.sv */
// ----------------------------------------------------------------------------
// stereo_biquad_filter
// Direct form I biquad with one history entry per channel in a small RAM.
//
//   channel  | handshake             | payload
//   ---------+-----------------------+--------------------------
//   input    | in_valid / in_ready   | channel, sample_in
//   output   | out_valid / out_ready | sample_out
//   config   | cfg_valid / cfg_ready | cfg_addr, cfg_data
//
// A request waits while its channel is in any of the three stages ahead of
// the output, until its history is written back, so a channel takes a new
// request only after its last one is written back; the other channel may go on.
// Reset clears the coefficients to pass-through and marks all history zero.
// A stalled output holds only the stages behind it that are full.
// ----------------------------------------------------------------------------
module stereo_biquad_filter (
  input  logic                                   clk,
  input  logic                                   rst,
  input  logic                                   in_valid,
  output logic                                   in_ready,
  input  logic                                   channel,
  input  logic signed [bqf_pkg::SAMPLE_W-1:0]    sample_in,
  output logic                                   out_valid,
  input  logic                                   out_ready,
  output logic signed [bqf_pkg::SAMPLE_W-1:0]    sample_out,
  input  logic                                   cfg_valid,
  output logic                                   cfg_ready,
  input  logic [bqf_pkg::CFG_ADDR_W-1:0]         cfg_addr,
  input  logic [bqf_pkg::COEF_W-1:0]             cfg_data
);

  bqf_pkg::coef_t coef;

  bqf_coef_regs u_coef_regs (
    .clk       (clk),
    .rst       (rst),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_addr  (cfg_addr),
    .cfg_data  (cfg_data),
    .coef      (coef)
  );

  // Stage enables, from the output backward
  logic en_out, en3, en2, en1;
  logic in_accept, hazard, wr_en;
  logic [bqf_pkg::CH_IDX_W-1:0] in_idx;

  // Stage 1: RAM read data
  logic                                 v1;
  logic [bqf_pkg::CH_IDX_W-1:0]         idx1;
  logic signed [bqf_pkg::SAMPLE_W-1:0]  x_s1;
  bqf_pkg::hist_t                       rd_hist;
  logic                                 rd_vld;
  bqf_pkg::hist_t                       hist1;

  // Stage 2: products
  logic                                 v2;
  logic [bqf_pkg::CH_IDX_W-1:0]         idx2;
  logic signed [bqf_pkg::PROD_W-1:0]    p0, p1, p2, p3, p4;
  logic signed [bqf_pkg::SAMPLE_W-1:0]  x_s2, xd1_s2, yd1_s2;

  // Stage 3: partial sums
  logic                                 v3;
  logic [bqf_pkg::CH_IDX_W-1:0]         idx3;
  logic signed [bqf_pkg::SUM_W-1:0]     sa, sb;
  logic signed [bqf_pkg::SAMPLE_W-1:0]  x_s3, xd1_s3, yd1_s3;

  logic signed [bqf_pkg::ACC_W-1:0]     acc;
  logic [bqf_pkg::Q_W-1:0]              q;
  logic signed [bqf_pkg::SAMPLE_W-1:0]  y;
  bqf_pkg::hist_t                       wb_hist;

  // History RAM with a valid bit per entry
  bqf_pkg::hist_t                       mem [bqf_pkg::CHANNELS];
  logic [bqf_pkg::CHANNELS-1:0]         mem_vld;

  assign en_out = !out_valid || out_ready;
  assign en3    = !v3 || en_out;
  assign en2    = !v2 || en3;
  assign en1    = !v1 || en2;

  assign in_idx = bqf_pkg::chan_index(channel);
  assign hazard = (v1 && idx1 == in_idx) || (v2 && idx2 == in_idx) ||
                  (v3 && idx3 == in_idx);
  assign in_ready  = en1 && !hazard;
  assign in_accept = in_valid && in_ready;
  assign wr_en     = v3 && en_out;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[idx3] <= wb_hist;
    end
    if (en1) begin
      rd_hist <= mem[in_idx];
      rd_vld  <= mem_vld[in_idx];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      mem_vld <= '0;
    end else if (wr_en) begin
      mem_vld[idx3] <= 1'b1;
    end
  end

  // Entries never written read as zero history
  assign hist1 = rd_vld ? rd_hist : '0;

  // Control: stage valids
  always_ff @(posedge clk) begin
    if (rst) begin
      v1        <= 1'b0;
      v2        <= 1'b0;
      v3        <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      if (en1)    v1        <= in_accept;
      if (en2)    v2        <= v1;
      if (en3)    v3        <= v2;
      if (en_out) out_valid <= v3;
    end
  end

  // Payload stages
  always_ff @(posedge clk) begin
    if (en1) begin
      idx1 <= in_idx;
      x_s1 <= sample_in;
    end
    if (en2) begin
      idx2   <= idx1;
      p0     <= $signed(coef.b0) * $signed(x_s1);
      p1     <= $signed(coef.b1) * $signed(hist1.x1);
      p2     <= $signed(coef.b2) * $signed(hist1.x2);
      p3     <= $signed(coef.a1) * $signed(hist1.y1);
      p4     <= $signed(coef.a2) * $signed(hist1.y2);
      x_s2   <= x_s1;
      xd1_s2 <= hist1.x1;
      yd1_s2 <= hist1.y1;
    end
    if (en3) begin
      idx3   <= idx2;
      sa     <= bqf_pkg::SUM_W'(p0) + bqf_pkg::SUM_W'(p1) + bqf_pkg::SUM_W'(p2);
      sb     <= bqf_pkg::SUM_W'(p3) + bqf_pkg::SUM_W'(p4);
      x_s3   <= x_s2;
      xd1_s3 <= xd1_s2;
      yd1_s3 <= yd1_s2;
    end
    if (en_out && v3) begin
      sample_out <= y;
    end
  end

  // Round half up to Q1.23, then clamp
  assign acc = bqf_pkg::ACC_W'(sa) - bqf_pkg::ACC_W'(sb) + bqf_pkg::ROUND_BIAS;
  assign q   = acc[bqf_pkg::ACC_W-1:bqf_pkg::FRAC_SHIFT];

  always_comb begin
    if ((&q[bqf_pkg::Q_W-1:bqf_pkg::SAMPLE_W-1]) ||
        !(|q[bqf_pkg::Q_W-1:bqf_pkg::SAMPLE_W-1])) begin
      y = q[bqf_pkg::SAMPLE_W-1:0];
    end else if (q[bqf_pkg::Q_W-1]) begin
      y = bqf_pkg::SAT_MIN;
    end else begin
      y = bqf_pkg::SAT_MAX;
    end
  end

  always_comb begin
    wb_hist.x1 = x_s3;
    wb_hist.x2 = xd1_s3;
    wb_hist.y1 = y;
    wb_hist.y2 = yd1_s3;
  end

`ifndef SYNTHESIS
  // Interlock: a channel is never read while its write-back is pending
  assert property (@(posedge clk) disable iff (rst)
    (v1 && v3) |-> (idx1 != idx3))
    else $error("history read overlaps pending write-back");

  assert property (@(posedge clk) disable iff (rst)
    (v1 && v2) |-> (idx1 != idx2))
    else $error("two requests on one channel in flight");

  // A write-back always lands in the output register
  assert property (@(posedge clk) disable iff (rst)
    wr_en |=> (out_valid && sample_out == $past(y)))
    else $error("write-back without matching output");

  // A stalled last stage keeps its sums
  assert property (@(posedge clk) disable iff (rst)
    (v3 && !en_out) |=> (v3 && $stable(sa) && $stable(sb) && $stable(idx3)))
    else $error("stage three lost data under stall");
`endif

endmodule
